// ===== sv/ifl_pkg.sv =====
package ifl_pkg;

  localparam int DIM_BITS = 14;
  localparam int CFG_IDX_BITS = 8;
  localparam int CFG_DATA_BITS = 8;

  typedef logic [DIM_BITS-1:0] dim_t;
  typedef logic [DIM_BITS-2:0] ofs_t;
  typedef logic [2*DIM_BITS-1:0] prod_t;
  typedef logic signed [DIM_BITS:0] sdim_t;

  typedef enum logic [1:0] {
    SCALE_NONE    = 2'd0,
    SCALE_FIT     = 2'd1,
    SCALE_FILL    = 2'd2,
    SCALE_STRETCH = 2'd3
  } scale_t;

  // what the quotient stands for once it leaves the divider
  typedef enum logic [2:0] {
    SEL_PASS   = 3'd0,
    SEL_FIT_H  = 3'd1,
    SEL_FIT_W  = 3'd2,
    SEL_CROP_H = 3'd3,
    SEL_CROP_W = 3'd4
  } sel_t;

  typedef enum logic [1:0] {
    POS_START = 2'd0,
    POS_MID   = 2'd1,
    POS_END   = 2'd2
  } pos_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_ALIGN = CFG_IDX_BITS'(1);

  localparam logic [3:0] ALIGN_TL = 4'd0;
  localparam logic [3:0] ALIGN_T  = 4'd1;
  localparam logic [3:0] ALIGN_TR = 4'd2;
  localparam logic [3:0] ALIGN_L  = 4'd3;
  localparam logic [3:0] ALIGN_C  = 4'd4;
  localparam logic [3:0] ALIGN_R  = 4'd5;
  localparam logic [3:0] ALIGN_BL = 4'd6;
  localparam logic [3:0] ALIGN_B  = 4'd7;
  localparam logic [3:0] ALIGN_BR = 4'd8;

  typedef struct packed {
    logic       zero;
    scale_t     scale;
    logic [3:0] align;
    sel_t       sel;
    dim_t       iw;
    dim_t       ih;
    dim_t       bw;
    dim_t       bh;
  } ctx_t;

  // unknown alignments fall to top-left
  function automatic pos_t align_col(logic [3:0] a);
    pos_t p;
    unique case (a)
      ALIGN_T, ALIGN_C, ALIGN_B:    p = POS_MID;
      ALIGN_TR, ALIGN_R, ALIGN_BR:  p = POS_END;
      default:                      p = POS_START;
    endcase
    return p;
  endfunction

  function automatic pos_t align_row(logic [3:0] a);
    pos_t p;
    unique case (a)
      ALIGN_L, ALIGN_C, ALIGN_R:    p = POS_MID;
      ALIGN_BL, ALIGN_B, ALIGN_BR:  p = POS_END;
      default:                      p = POS_START;
    endcase
    return p;
  endfunction

  function automatic sdim_t place(pos_t p, dim_t box, dim_t dim);
    sdim_t diff;
    sdim_t half;
    sdim_t r;
    diff = $signed({1'b0, box}) - $signed({1'b0, dim});
    half = diff >>> 1;
    // round toward zero for odd negatives
    if (diff[DIM_BITS] && diff[0]) half = half + sdim_t'(1);
    case (p)
      POS_MID: r = half;
      POS_END: r = diff;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/ifl_front.sv =====
module ifl_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ifl_pkg::dim_t   iw,
  input  ifl_pkg::dim_t   ih,
  input  ifl_pkg::dim_t   bw,
  input  ifl_pkg::dim_t   bh,
  input  ifl_pkg::scale_t scale,
  input  logic [3:0]      align,
  output logic            out_valid,
  input  logic            out_ready,
  output ifl_pkg::prod_t  num,
  output ifl_pkg::dim_t   den,
  output ifl_pkg::ctx_t   ctx
);

  logic           v1, v2;
  logic           adv1, adv2;
  ifl_pkg::prod_t pa, pb;
  ifl_pkg::ctx_t  c1, c2;
  ifl_pkg::ctx_t  c1_sel;
  ifl_pkg::prod_t num_r;
  ifl_pkg::dim_t  den_r;
  ifl_pkg::prod_t num_next;
  ifl_pkg::dim_t  den_next;
  ifl_pkg::sel_t  sel_next;

  assign adv2 = !v2 || out_ready;
  assign adv1 = !v1 || adv2;
  assign in_ready = adv1;

  // pa = bw*ih, pb = bh*iw; all ratio tests compare these
  always_comb begin
    sel_next = ifl_pkg::SEL_PASS;
    num_next = '0;
    den_next = ifl_pkg::dim_t'(1);
    if (!c1.zero) begin
      case (c1.scale)
        ifl_pkg::SCALE_FIT: begin
          if (pa < pb) begin
            sel_next = ifl_pkg::SEL_FIT_H;
            num_next = pa;
            den_next = c1.iw;
          end else begin
            sel_next = ifl_pkg::SEL_FIT_W;
            num_next = pb;
            den_next = c1.ih;
          end
        end
        ifl_pkg::SCALE_FILL: begin
          // floor(ih*bw/iw) > bh  <=>  pa - pb >= iw
          if (pa > pb) begin
            if ((pa - pb) >= ifl_pkg::prod_t'(c1.iw)) begin
              sel_next = ifl_pkg::SEL_CROP_H;
              num_next = pb;
              den_next = c1.bw;
            end
          end else if ((pb - pa) >= ifl_pkg::prod_t'(c1.ih)) begin
            sel_next = ifl_pkg::SEL_CROP_W;
            num_next = pa;
            den_next = c1.bh;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    c1_sel     = c1;
    c1_sel.sel = sel_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
    end
    if (adv1 && in_valid) begin
      pa       <= bw * ih;
      pb       <= bh * iw;
      c1.zero  <= (iw == '0) || (ih == '0);
      c1.scale <= scale;
      c1.align <= align;
      c1.sel   <= ifl_pkg::SEL_PASS;
      c1.iw    <= iw;
      c1.ih    <= ih;
      c1.bw    <= bw;
      c1.bh    <= bh;
    end
    if (adv2 && v1) begin
      num_r <= num_next;
      den_r <= den_next;
      c2    <= c1_sel;
    end
  end

  assign out_valid = v2;
  assign num = num_r;
  assign den = den_r;
  assign ctx = c2;

endmodule

// ===== sv/ifl_div.sv =====
module ifl_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ifl_pkg::prod_t num,
  input  ifl_pkg::dim_t  den,
  input  ifl_pkg::ctx_t  ctx_in,
  output logic           out_valid,
  input  logic           out_ready,
  output ifl_pkg::dim_t  quot,
  output ifl_pkg::ctx_t  ctx_out
);

  localparam int D = ifl_pkg::DIM_BITS;

  // one quotient bit per stage; the quotient is known to fit in D bits
  logic          v   [D];
  logic          adv [D+1];
  ifl_pkg::dim_t rem [D];
  ifl_pkg::dim_t low [D];
  ifl_pkg::dim_t q   [D];
  ifl_pkg::dim_t dn  [D];
  ifl_pkg::ctx_t cx  [D];

  assign adv[D] = out_ready;

  for (genvar i = 0; i < D; i++) begin : g_stage
    logic          vin;
    ifl_pkg::dim_t rem_in, low_in, q_in, dn_in;
    ifl_pkg::ctx_t cx_in;
    logic [D:0]    t;
    logic          ge;
    logic [D:0]    nr;

    if (i == 0) begin : g_first
      assign vin    = in_valid;
      assign rem_in = num[2*D-1:D];
      assign low_in = num[D-1:0];
      assign q_in   = '0;
      assign dn_in  = den;
      assign cx_in  = ctx_in;
    end else begin : g_next
      assign vin    = v[i-1];
      assign rem_in = rem[i-1];
      assign low_in = low[i-1];
      assign q_in   = q[i-1];
      assign dn_in  = dn[i-1];
      assign cx_in  = cx[i-1];
    end

    assign adv[i] = !v[i] || adv[i+1];
    assign t  = {rem_in, low_in[D-1]};
    assign ge = t >= {1'b0, dn_in};
    assign nr = ge ? (t - {1'b0, dn_in}) : t;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (adv[i]) begin
        v[i] <= vin;
      end
      if (adv[i] && vin) begin
        rem[i] <= nr[D-1:0];
        low[i] <= {low_in[D-2:0], 1'b0};
        q[i]   <= {q_in[D-2:0], ge};
        dn[i]  <= dn_in;
        cx[i]  <= cx_in;
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[D-1];
  assign quot      = q[D-1];
  assign ctx_out   = cx[D-1];

endmodule

// ===== sv/ifl_back.sv =====
module ifl_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ifl_pkg::dim_t        quot,
  input  ifl_pkg::ctx_t        ctx,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 layout_valid,
  output ifl_pkg::ofs_t        src_x,
  output ifl_pkg::ofs_t        src_y,
  output ifl_pkg::dim_t        src_w,
  output ifl_pkg::dim_t        src_h,
  output logic signed [ifl_pkg::DIM_BITS:0] dst_x,
  output logic signed [ifl_pkg::DIM_BITS:0] dst_y,
  output ifl_pkg::dim_t        dst_w,
  output ifl_pkg::dim_t        dst_h
);

  logic          ov;
  logic          adv;
  ifl_pkg::dim_t sw, sh, dw, dh, xdiff, ydiff;
  ifl_pkg::ofs_t sx, sy;
  ifl_pkg::sdim_t dx, dy;

  assign adv = !ov || out_ready;
  assign in_ready = adv;
  assign xdiff = ctx.iw - quot;
  assign ydiff = ctx.ih - quot;

  always_comb begin
    sx = '0;
    sy = '0;
    sw = ctx.iw;
    sh = ctx.ih;
    if (ctx.scale == ifl_pkg::SCALE_NONE) begin
      dw = ctx.iw;
      dh = ctx.ih;
    end else begin
      dw = ctx.bw;
      dh = ctx.bh;
    end
    case (ctx.sel)
      ifl_pkg::SEL_FIT_H:  dh = quot;
      ifl_pkg::SEL_FIT_W:  dw = quot;
      ifl_pkg::SEL_CROP_H: begin
        sh = quot;
        sy = ydiff[ifl_pkg::DIM_BITS-1:1];
      end
      ifl_pkg::SEL_CROP_W: begin
        sw = quot;
        sx = xdiff[ifl_pkg::DIM_BITS-1:1];
      end
      default: ;
    endcase
    dx = ifl_pkg::place(ifl_pkg::align_col(ctx.align), ctx.bw, dw);
    dy = ifl_pkg::place(ifl_pkg::align_row(ctx.align), ctx.bh, dh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= in_valid;
    end
    if (adv && in_valid) begin
      if (ctx.zero) begin
        layout_valid <= 1'b0;
        src_x <= '0;
        src_y <= '0;
        src_w <= '0;
        src_h <= '0;
        dst_x <= '0;
        dst_y <= '0;
        dst_w <= '0;
        dst_h <= '0;
      end else begin
        layout_valid <= 1'b1;
        src_x <= sx;
        src_y <= sy;
        src_w <= sw;
        src_h <= sh;
        dst_x <= dx;
        dst_y <= dy;
        dst_w <= dw;
        dst_h <= dh;
      end
    end
  end

  assign out_valid = ov;

endmodule

// ===== sv/image_fit_fill_layout.sv =====
// Pipeline: 2 product/select stages, 14 divider stages at one quotient bit
// each, 1 output register. Throughput: one beat per cycle while out_ready
// is high; each stage advances on its own when the next one is free, so
// bubbles are squeezed out under output stalls.
// Reset (rst, synchronous): empties the pipeline, fit_mode = fit, align = center.
module image_fit_fill_layout (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ifl_pkg::DIM_BITS-1:0]         image_width,
  input  logic [ifl_pkg::DIM_BITS-1:0]         image_height,
  input  logic [ifl_pkg::DIM_BITS-1:0]         box_width,
  input  logic [ifl_pkg::DIM_BITS-1:0]         box_height,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 layout_valid,
  output logic [ifl_pkg::DIM_BITS-2:0]         src_x,
  output logic [ifl_pkg::DIM_BITS-2:0]         src_y,
  output logic [ifl_pkg::DIM_BITS-1:0]         src_w,
  output logic [ifl_pkg::DIM_BITS-1:0]         src_h,
  output logic signed [ifl_pkg::DIM_BITS:0]    dst_x,
  output logic signed [ifl_pkg::DIM_BITS:0]    dst_y,
  output logic [ifl_pkg::DIM_BITS-1:0]         dst_w,
  output logic [ifl_pkg::DIM_BITS-1:0]         dst_h,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ifl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [ifl_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  ifl_pkg::scale_t fit_mode;
  logic [3:0]      align_mode;

  logic           f_valid, f_ready;
  ifl_pkg::prod_t f_num;
  ifl_pkg::dim_t  f_den;
  ifl_pkg::ctx_t  f_ctx;
  logic           d_valid, d_ready;
  ifl_pkg::dim_t  d_quot;
  ifl_pkg::ctx_t  d_ctx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode   <= ifl_pkg::SCALE_FIT;
      align_mode <= ifl_pkg::ALIGN_C;
    end else if (cfg_valid) begin
      if (cfg_index == ifl_pkg::REG_SCALE) begin
        fit_mode <= ifl_pkg::scale_t'(cfg_data[1:0]);
      end else if (cfg_index == ifl_pkg::REG_ALIGN) begin
        align_mode <= cfg_data[3:0];
      end
    end
  end

  ifl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .iw        (image_width),
    .ih        (image_height),
    .bw        (box_width),
    .bh        (box_height),
    .scale     (fit_mode),
    .align     (align_mode),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .num       (f_num),
    .den       (f_den),
    .ctx       (f_ctx)
  );

  ifl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .num       (f_num),
    .den       (f_den),
    .ctx_in    (f_ctx),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .quot      (d_quot),
    .ctx_out   (d_ctx)
  );

  ifl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (d_valid),
    .in_ready     (d_ready),
    .quot         (d_quot),
    .ctx          (d_ctx),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .layout_valid (layout_valid),
    .src_x        (src_x),
    .src_y        (src_y),
    .src_w        (src_w),
    .src_h        (src_h),
    .dst_x        (dst_x),
    .dst_y        (dst_y),
    .dst_w        (dst_w),
    .dst_h        (dst_h)
  );

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !layout_valid |-> src_w == '0 && src_h == '0 && dst_w == '0 && dst_h == '0)
    else $error("invalid layout with nonzero fields");

  a_one_axis_crop: assert property (@(posedge clk) disable iff (rst)
    out_valid && src_x != '0 |-> src_y == '0)
    else $error("crop on both axes");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result out of reset");

  a_divider_drains: assert property (@(posedge clk) disable iff (rst)
    d_valid && !d_ready |=> d_valid)
    else $error("divider beat lost under stall");

endmodule
